>>> hdl/bmp_pkg.sv
`default_nettype none

package bmp_pkg;

  // Default limits of the decoder.
  localparam int DefMaxWidth     = 4096;
  localparam int DefMaxHeight    = 4096;
  localparam int DefPaletteSlots = 256;

  // Size of the fixed file header in bytes.
  localparam logic [31:0] HDR_BYTES = 32'd54;

  // Result kinds.
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_PALETTE = 3'd1;
  localparam logic [2:0] KIND_PIXEL   = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Error codes.
  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_SHORT_HEADER  = 4'd1;
  localparam logic [3:0] ERR_SIGNATURE     = 4'd2;
  localparam logic [3:0] ERR_DEPTH         = 4'd3;
  localparam logic [3:0] ERR_COMPRESSED    = 4'd4;
  localparam logic [3:0] ERR_DIMENSIONS    = 4'd5;
  localparam logic [3:0] ERR_COLORS        = 4'd6;
  localparam logic [3:0] ERR_PALETTE_SHORT = 4'd7;
  localparam logic [3:0] ERR_OFFSET        = 4'd8;
  localparam logic [3:0] ERR_PIXELS_SHORT  = 4'd9;

  // File signature "BM", first byte in the low half.
  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  // Color that stands for an unused palette slot.
  localparam logic [15:0] UNUSED_COLOR = 16'hF81F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] column;
    logic [11:0] row;
    logic [15:0] value;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [3:0]  pixel_depth;
    logic [8:0]  color_count;
    logic [3:0]  error_code;
    logic        last;
  } result_t;

  // Up to three results produced by one input byte.
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     item;
  } push_t;

endpackage

`default_nettype wire

>>> hdl/bmp_stream_if.sv
`default_nettype none

// Valid/ready stream carrying one payload of type T per transfer.
interface bmp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/bmp_parse.sv
`default_nettype none

module bmp_parse
  import bmp_pkg::*;
#(
  parameter int MAX_WIDTH     = DefMaxWidth,
  parameter int MAX_HEIGHT    = DefMaxHeight,
  parameter int PALETTE_SLOTS = DefPaletteSlots
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  input  wire logic  accept_i,
  input  wire in_t   byte_i,
  output push_t      push_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int SW = $clog2(PALETTE_SLOTS + 1);
  localparam int BW = WW + 1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_GAP,
    PH_PIXELS,
    PH_IDLE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [15:0] sig_q, sig_d;
  logic [31:0] off_q, off_d;
  logic [15:0] depth_q, depth_d;
  logic [31:0] width_q, width_d;
  logic [31:0] hraw_q, hraw_d;
  logic [31:0] comp_q, comp_d;
  logic [31:0] cnt_raw_q, cnt_raw_d;
  logic        bottom_up_q, bottom_up_d;
  logic        is8_q, is8_d;
  logic [HW-1:0] height_q, height_d;
  logic [SW-1:0] count_q, count_d;
  logic [WW-1:0] img_w_q, img_w_d;
  logic [BW-1:0] stride_q, stride_d;
  logic [BW-1:0] copy_q, copy_d;
  logic [23:0] pal_q, pal_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [HW-1:0] row_q, row_d;
  logic [BW-1:0] rbyte_q, rbyte_d;
  logic [WW-1:0] col_q, col_d;
  logic        mask_q;

  // Header checks, evaluated from the stored header fields.
  logic [32:0] h_ext, habs;
  logic [31:0] cnt_eff;
  logic [11:0] min_off;
  logic [3:0]  hdr_err;
  logic [BW-1:0] w_ext, stride_calc, copy_calc;

  function automatic result_t mk(logic [2:0] kind, logic [11:0] col, logic [11:0] row,
                                 logic [15:0] val, logic [3:0] err);
    result_t r;
    r            = '0;
    r.kind       = kind;
    r.column     = col;
    r.row        = row;
    r.value      = val;
    r.error_code = err;
    return r;
  endfunction

  always_comb begin
    h_ext   = {hraw_q[31], hraw_q};
    habs    = hraw_q[31] ? (33'd0 - h_ext) : h_ext;
    cnt_eff = (cnt_raw_q == 32'd0) ? ((depth_q == 16'd8) ? 32'd256 : 32'd16) : cnt_raw_q;
    min_off = 12'd54 + {1'b0, cnt_eff[8:0], 2'b00};
    if (sig_q != BMP_SIGNATURE) begin
      hdr_err = ERR_SIGNATURE;
    end else if (depth_q != 16'd4 && depth_q != 16'd8) begin
      hdr_err = ERR_DEPTH;
    end else if (comp_q != 32'd0) begin
      hdr_err = ERR_COMPRESSED;
    end else if (width_q[31] || width_q == 32'd0 || hraw_q == 32'd0) begin
      hdr_err = ERR_DIMENSIONS;
    end else if (width_q > 32'(MAX_WIDTH) || habs > 33'(MAX_HEIGHT)) begin
      hdr_err = ERR_DIMENSIONS;
    end else if (cnt_eff[31] || cnt_eff > 32'(PALETTE_SLOTS)) begin
      hdr_err = ERR_COLORS;
    end else if (off_q[31] || off_q < 32'(min_off)) begin
      hdr_err = ERR_OFFSET;
    end else begin
      hdr_err = ERR_NONE;
    end
    // Row stride rounds up to whole 32-bit words; copy is the bytes holding pixels.
    w_ext = {1'b0, width_q[WW-1:0]};
    if (depth_q == 16'd8) begin
      stride_calc = (w_ext + BW'(3)) & ~BW'(3);
      copy_calc   = w_ext;
    end else begin
      stride_calc = ((w_ext + BW'(7)) >> 3) << 2;
      copy_calc   = (w_ext + BW'(1)) >> 1;
    end
  end

  // Per-byte next state and results.
  logic [7:0]    b;
  logic [31:0]   pos_inc;
  logic [5:0]    pos6;
  logic [1:0]    sub;
  logic [23:0]   c;
  logic [SW-1:0] slot_inc;
  logic [HW-1:0] orow, row_inc;
  logic [WW-1:0] col_inc;
  logic [BW-1:0] rb_inc;
  logic [1:0]    n_v;
  result_t [2:0] res;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    sig_d       = sig_q;
    off_d       = off_q;
    depth_d     = depth_q;
    width_d     = width_q;
    hraw_d      = hraw_q;
    comp_d      = comp_q;
    cnt_raw_d   = cnt_raw_q;
    bottom_up_d = bottom_up_q;
    is8_d       = is8_q;
    height_d    = height_q;
    count_d     = count_q;
    img_w_d     = img_w_q;
    stride_d    = stride_q;
    copy_d      = copy_q;
    pal_d       = pal_q;
    slot_d      = slot_q;
    row_d       = row_q;
    rbyte_d     = rbyte_q;
    col_d       = col_q;
    res         = '0;
    n_v         = 2'd0;
    b           = byte_i.data_byte;
    pos_inc     = pos_q + 32'd1;
    pos6        = pos_q[5:0];
    sub         = pos_q[1:0] + 2'd2;
    c           = pal_q;
    slot_inc    = slot_q + SW'(1);
    orow        = bottom_up_q ? (height_q - HW'(1) - row_q) : row_q;
    row_inc     = row_q + HW'(1);
    col_inc     = col_q + WW'(1);
    rb_inc      = rbyte_q + BW'(1);

    case (phase_q)
      PH_HEADER: begin
        if (pos6 < 6'd2) sig_d[{pos6[0], 3'b000} +: 8] = b;
        if (pos6 >= 6'd10 && pos6 <= 6'd13) off_d[{2'(pos6 - 6'd10), 3'b000} +: 8] = b;
        if (pos6 >= 6'd18 && pos6 <= 6'd21) width_d[{2'(pos6 - 6'd18), 3'b000} +: 8] = b;
        if (pos6 >= 6'd22 && pos6 <= 6'd25) hraw_d[{2'(pos6 - 6'd22), 3'b000} +: 8] = b;
        if (pos6 >= 6'd28 && pos6 <= 6'd29) depth_d[{pos6[0], 3'b000} +: 8] = b;
        if (pos6 >= 6'd30 && pos6 <= 6'd33) comp_d[{2'(pos6 - 6'd30), 3'b000} +: 8] = b;
        if (pos6 >= 6'd46 && pos6 <= 6'd49) cnt_raw_d[{2'(pos6 - 6'd46), 3'b000} +: 8] = b;
        pos_d = pos_inc;
        if (pos_inc == HDR_BYTES) begin
          if (hdr_err != ERR_NONE) begin
            res[n_v] = mk(KIND_ERROR, 12'd0, 12'd0, 16'd0, hdr_err);
            n_v      = n_v + 2'd1;
            phase_d  = PH_IDLE;
          end else begin
            res[n_v]              = mk(KIND_HEADER, 12'd0, 12'd0, 16'd0, ERR_NONE);
            res[n_v].image_width  = width_q[12:0];
            res[n_v].image_height = habs[12:0];
            res[n_v].pixel_depth  = depth_q[3:0];
            res[n_v].color_count  = cnt_eff[8:0];
            n_v         = n_v + 2'd1;
            bottom_up_d = !hraw_q[31];
            height_d    = habs[HW-1:0];
            count_d     = cnt_eff[SW-1:0];
            img_w_d     = width_q[WW-1:0];
            is8_d       = (depth_q == 16'd8);
            stride_d    = stride_calc;
            copy_d      = copy_calc;
            phase_d     = PH_PALETTE;
          end
        end
      end
      PH_PALETTE: begin
        if (sub != 2'd3) begin
          pal_d[{sub, 3'b000} +: 8] = b;
        end else begin
          if (mask_q && pal_q < 24'd8) c = 24'd8;
          res[n_v] = mk(KIND_PALETTE, 12'(slot_q), 12'd0,
                        {c[23:19], c[15:10], c[7:3]}, ERR_NONE);
          n_v    = n_v + 2'd1;
          pal_d  = '0;
          slot_d = slot_inc;
          if (slot_inc >= count_q) begin
            phase_d = (off_q == pos_inc) ? PH_PIXELS : PH_GAP;
          end
        end
        pos_d = pos_inc;
      end
      PH_GAP: begin
        pos_d = pos_inc;
        if (off_q == pos_inc) phase_d = PH_PIXELS;
      end
      PH_PIXELS: begin
        if (rbyte_q < copy_q) begin
          if (is8_q) begin
            res[n_v] = mk(KIND_PIXEL, 12'(col_q), 12'(orow), {8'd0, b}, ERR_NONE);
            n_v      = n_v + 2'd1;
            col_d    = col_inc;
          end else begin
            res[n_v] = mk(KIND_PIXEL, 12'(col_q), 12'(orow), {12'd0, b[7:4]}, ERR_NONE);
            n_v      = n_v + 2'd1;
            col_d    = col_inc;
            if (col_inc < img_w_q) begin
              res[n_v] = mk(KIND_PIXEL, 12'(col_inc), 12'(orow), {12'd0, b[3:0]}, ERR_NONE);
              n_v      = n_v + 2'd1;
              col_d    = col_inc + WW'(1);
            end
          end
        end
        rbyte_d = rb_inc;
        if (rb_inc >= stride_q) begin
          rbyte_d = '0;
          col_d   = '0;
          row_d   = row_inc;
          if (row_inc >= height_q) begin
            res[n_v] = mk(KIND_DONE, 12'd0, 12'd0, 16'd0, ERR_NONE);
            n_v      = n_v + 2'd1;
            phase_d  = PH_IDLE;
          end
        end
        pos_d = pos_inc;
      end
      default: begin
      end
    endcase

    // The last byte of a file reports unfinished work, then clears file state.
    if (byte_i.final_byte) begin
      if (phase_d == PH_HEADER) begin
        res[n_v] = mk(KIND_ERROR, 12'd0, 12'd0, 16'd0, ERR_SHORT_HEADER);
        n_v      = n_v + 2'd1;
      end else if (phase_d == PH_PALETTE) begin
        res[n_v] = mk(KIND_ERROR, 12'd0, 12'd0, 16'd0, ERR_PALETTE_SHORT);
        n_v      = n_v + 2'd1;
      end else if (phase_d == PH_GAP || phase_d == PH_PIXELS) begin
        res[n_v] = mk(KIND_ERROR, 12'd0, 12'd0, 16'd0, ERR_PIXELS_SHORT);
        n_v      = n_v + 2'd1;
      end
      phase_d     = PH_HEADER;
      pos_d       = '0;
      sig_d       = '0;
      off_d       = '0;
      depth_d     = '0;
      width_d     = '0;
      hraw_d      = '0;
      comp_d      = '0;
      cnt_raw_d   = '0;
      bottom_up_d = 1'b0;
      height_d    = '0;
      count_d     = '0;
      pal_d       = '0;
      slot_d      = '0;
      row_d       = '0;
      rbyte_d     = '0;
      col_d       = '0;
    end

    if (n_v != 2'd0) res[n_v - 2'd1].last = 1'b1;
    push_o.count = n_v;
    push_o.item  = res;
  end

  // File state advances only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      sig_q       <= '0;
      off_q       <= '0;
      depth_q     <= '0;
      width_q     <= '0;
      hraw_q      <= '0;
      comp_q      <= '0;
      cnt_raw_q   <= '0;
      bottom_up_q <= 1'b0;
      is8_q       <= 1'b0;
      height_q    <= '0;
      count_q     <= '0;
      img_w_q     <= '0;
      stride_q    <= '0;
      copy_q      <= '0;
      pal_q       <= '0;
      slot_q      <= '0;
      row_q       <= '0;
      rbyte_q     <= '0;
      col_q       <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      sig_q       <= sig_d;
      off_q       <= off_d;
      depth_q     <= depth_d;
      width_q     <= width_d;
      hraw_q      <= hraw_d;
      comp_q      <= comp_d;
      cnt_raw_q   <= cnt_raw_d;
      bottom_up_q <= bottom_up_d;
      is8_q       <= is8_d;
      height_q    <= height_d;
      count_q     <= count_d;
      img_w_q     <= img_w_d;
      stride_q    <= stride_d;
      copy_q      <= copy_d;
      pal_q       <= pal_d;
      slot_q      <= slot_d;
      row_q       <= row_d;
      rbyte_q     <= rbyte_d;
      col_q       <= col_d;
    end
  end

  // Transparency option register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 1'b0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bmp_outq.sv
`default_nettype none

module bmp_outq
  import bmp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_en_i,
  input  wire push_t   push_i,
  output logic         ready_o,
  bmp_stream_if.source result_o
);

  result_t     mem_q [4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  add;
  logic        pop;

  // Room for a full burst of three results is needed to take a byte.
  assign ready_o        = (cnt_q <= 3'd1);
  assign result_o.valid = (cnt_q != 3'd0);
  assign result_o.data  = mem_q[rd_q];
  assign pop            = result_o.valid && result_o.ready;
  assign add            = push_en_i ? {1'b0, push_i.count} : 3'd0;
  assign cnt_d          = cnt_q + add - {2'b00, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + add[1:0];
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_d;
    end
  end

  // Result storage, written in burst order.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (push_en_i && 2'(k) < push_i.count) begin
        mem_q[wr_q + 2'(k)] <= push_i.item[k];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/bmp_indexed_image_decoder.sv
`default_nettype none

// Streaming decoder for uncompressed 4- and 8-bit palettized BMP files. The file
// enters one byte per transfer on byte_i, with final_byte set on its last byte;
// results leave on result_o: header info, palette entries as RGB565, pixel
// indexes with column and top-down row, then done, or an error code. Results
// drain from a four-entry queue one per cycle while result_o is ready, so a
// byte that yields one result sustains one byte per cycle, while a 4bpp byte
// with two pixels stalls input until a result drains. The queue takes a byte
// only while at least three entries are free. cfg_wdata_i written with cfg_we_i
// sets the transparency clamp, and should change only while the decoder is idle.
module bmp_indexed_image_decoder
  import bmp_pkg::*;
#(
  parameter int MAX_WIDTH     = DefMaxWidth,
  parameter int MAX_HEIGHT    = DefMaxHeight,
  parameter int PALETTE_SLOTS = DefPaletteSlots
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    cfg_we_i,
  input  wire logic    cfg_wdata_i,
  bmp_stream_if.sink   byte_i,
  bmp_stream_if.source result_o
);

  logic  q_ready;
  logic  accept;
  push_t push;

  assign byte_i.ready = q_ready;
  assign accept       = byte_i.valid && q_ready;

  bmp_parse #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .PALETTE_SLOTS(PALETTE_SLOTS)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .byte_i     (byte_i.data),
    .push_o     (push)
  );

  bmp_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_en_i(accept),
    .push_i   (push),
    .ready_o  (q_ready),
    .result_o (result_o)
  );

  // Header info reports only a supported depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.kind == KIND_HEADER
    |-> result_o.data.pixel_depth == 4'd4 || result_o.data.pixel_depth == 4'd8)
    else $error("header result with unsupported depth");

  // An error result always carries a code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.kind == KIND_ERROR
    |-> result_o.data.error_code != ERR_NONE)
    else $error("error result without code");

  // A pixel value is a palette index of at most eight bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.kind == KIND_PIXEL
    |-> result_o.data.value[15:8] == 8'd0)
    else $error("pixel index out of range");

  // Palette entries stay within the configured slot count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.kind == KIND_PALETTE
    |-> result_o.data.column < 12'(PALETTE_SLOTS))
    else $error("palette slot out of range");

endmodule

`default_nettype wire

>>> tb/sv/bmp_indexed_image_decoder_tb.sv
module bmp_indexed_image_decoder_tb;
  import bmp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Decoder phases as tracked by the predictor.
  typedef enum logic [2:0] {
    ST_HEADER,
    ST_PALETTE,
    ST_GAP,
    ST_PIXELS,
    ST_IDLE
  } dec_state_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  bmp_stream_if #(.T(in_t))     byte_if ();
  bmp_stream_if #(.T(result_t)) res_if ();

  bmp_indexed_image_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .byte_i     (byte_if),
    .result_o   (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state, mirrored from the decoder's behavior.
  logic        clamp_black;
  dec_state_e  st;
  int unsigned file_pos;
  logic [63:0] hdr_word [4];
  logic        flip_rows;
  logic [31:0] color_acc;
  int unsigned slot_idx;
  int unsigned row_idx;
  int unsigned row_byte_idx;
  int unsigned col_idx;

  in_t     byte_queue [$];
  result_t step_results [$];
  result_t expected_results [$];

  int  mismatch_count = 0;
  bit  quiet = 1'b0;
  int  send_gap;
  int  recv_gap;
  int  hold_left;
  bit  held;
  int  results_seen;

  function automatic void clear_file();
    st = ST_HEADER;
    file_pos = 0;
    for (int i = 0; i < 4; i++) hdr_word[i] = '0;
    flip_rows = 1'b0;
    color_acc = '0;
    slot_idx = 0;
    row_idx = 0;
    row_byte_idx = 0;
    col_idx = 0;
  endfunction

  function automatic void emit(logic [2:0] kind, int unsigned col, int unsigned row,
                               int unsigned val, logic [3:0] err);
    result_t r;
    r = '0;
    r.kind = kind;
    r.column = col[11:0];
    r.row = row[11:0];
    r.value = val[15:0];
    r.error_code = err;
    step_results.push_back(r);
  endfunction

  function automatic void store_header_byte(int unsigned p, logic [7:0] b);
    if (p < 2) hdr_word[0] |= 64'(b) << (8 * p);
    else if (p >= 10 && p <= 13) hdr_word[0] |= 64'(b) << (32 + 8 * (p - 10));
    else if (p >= 28 && p <= 29) hdr_word[0] |= 64'(b) << (16 + 8 * (p - 28));
    else if (p >= 18 && p <= 25) hdr_word[1] |= 64'(b) << (8 * (p - 18));
    else if (p >= 30 && p <= 33) hdr_word[2] |= 64'(b) << (8 * (p - 30));
    else if (p >= 46 && p <= 49) hdr_word[2] |= 64'(b) << (32 + 8 * (p - 46));
  endfunction

  // Validates the collected header; returns the error code or none.
  function automatic logic [3:0] header_error();
    longint dep, w, h, cnt, off;
    dep = hdr_word[0][31:16];
    w = longint'($signed(hdr_word[1][31:0]));
    h = longint'($signed(hdr_word[1][63:32]));
    cnt = longint'($signed(hdr_word[2][63:32]));
    off = longint'($signed(hdr_word[0][63:32]));
    if (hdr_word[0][15:0] != BMP_SIGNATURE) return ERR_SIGNATURE;
    if (dep != 4 && dep != 8) return ERR_DEPTH;
    if (hdr_word[2][31:0] != 0) return ERR_COMPRESSED;
    if (w <= 0 || h == 0) return ERR_DIMENSIONS;
    if (h < 0) begin
      h = -h;
      flip_rows = 1'b0;
    end else begin
      flip_rows = 1'b1;
    end
    if (w > DefMaxWidth || h > DefMaxHeight) return ERR_DIMENSIONS;
    if (cnt == 0) cnt = longint'(1) << dep;
    if (cnt < 0 || cnt > DefPaletteSlots) return ERR_COLORS;
    if (off < 54 + 4 * cnt) return ERR_OFFSET;
    hdr_word[3] = 64'(cnt) | (64'(h) << 16);
    return ERR_NONE;
  endfunction

  // Works out the results of one accepted file byte.
  function automatic void predict_byte(logic [7:0] b, logic fin);
    int unsigned pos, sub;
    logic [3:0] err;
    logic [23:0] c;
    result_t r;
    longint unsigned w, bits, stride, copy, h, orow;
    pos = file_pos;
    step_results.delete();
    case (st)
      ST_HEADER: begin
        store_header_byte(pos, b);
        file_pos = pos + 1;
        if (pos + 1 == HDR_BYTES) begin
          err = header_error();
          if (err != ERR_NONE) begin
            emit(KIND_ERROR, 0, 0, 0, err);
            st = ST_IDLE;
          end else begin
            r = '0;
            r.kind = KIND_HEADER;
            r.image_width = hdr_word[1][12:0];
            r.image_height = hdr_word[3][28:16];
            r.pixel_depth = hdr_word[0][19:16];
            r.color_count = hdr_word[3][8:0];
            step_results.push_back(r);
            st = ST_PALETTE;
          end
        end
      end
      ST_PALETTE: begin
        sub = (pos - HDR_BYTES) & 3;
        if (sub < 3) begin
          color_acc |= 32'(b) << (8 * sub);
        end else begin
          c = color_acc[23:0];
          if (clamp_black && c < 8) c = 24'd8;
          emit(KIND_PALETTE, slot_idx, 0, {c[23:19], c[15:10], c[7:3]}, ERR_NONE);
          color_acc = '0;
          slot_idx++;
        end
        file_pos = pos + 1;
        if (sub == 3 && slot_idx >= hdr_word[3][15:0]) begin
          st = (hdr_word[0][63:32] == pos + 1) ? ST_PIXELS : ST_GAP;
        end
      end
      ST_GAP: begin
        file_pos = pos + 1;
        if (hdr_word[0][63:32] == pos + 1) st = ST_PIXELS;
      end
      ST_PIXELS: begin
        w = hdr_word[1][31:0];
        bits = hdr_word[0][31:16] * w;
        stride = ((bits + 31) / 32) * 4;
        copy = (bits + 7) / 8;
        h = hdr_word[3] >> 16;
        orow = flip_rows ? (h - 1 - row_idx) : row_idx;
        if (row_byte_idx < copy) begin
          if (hdr_word[0][31:16] == 8) begin
            emit(KIND_PIXEL, col_idx, orow, b, ERR_NONE);
            col_idx++;
          end else begin
            emit(KIND_PIXEL, col_idx, orow, b[7:4], ERR_NONE);
            col_idx++;
            if (col_idx < w) begin
              emit(KIND_PIXEL, col_idx, orow, b[3:0], ERR_NONE);
              col_idx++;
            end
          end
        end
        row_byte_idx++;
        if (row_byte_idx >= stride) begin
          row_byte_idx = 0;
          col_idx = 0;
          row_idx++;
          if (row_idx >= h) begin
            emit(KIND_DONE, 0, 0, 0, ERR_NONE);
            st = ST_IDLE;
          end
        end
        file_pos = pos + 1;
      end
      default: ;
    endcase
    if (fin) begin
      if (st == ST_HEADER) emit(KIND_ERROR, 0, 0, 0, ERR_SHORT_HEADER);
      else if (st == ST_PALETTE) emit(KIND_ERROR, 0, 0, 0, ERR_PALETTE_SHORT);
      else if (st == ST_GAP || st == ST_PIXELS) emit(KIND_ERROR, 0, 0, 0, ERR_PIXELS_SHORT);
      clear_file();
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  function automatic void put32(ref logic [7:0] hdr [54], input int at, input longint v);
    for (int i = 0; i < 4; i++) hdr[at + i] = v[8 * i +: 8];
  endfunction

  // Builds one file and queues its bytes. A cut of -1 picks a random early end,
  // 0 keeps the whole file. gap_bytes below zero moves the pixel data offset
  // into the palette by that many bytes.
  task automatic queue_file(bit sig_ok, int depth, longint comp, longint w, longint h,
                            longint cnt, longint gap_bytes, int cut, int junk);
    logic [7:0] hdr [54];
    logic [7:0] f [$];
    longint ce, off, stride, ah;
    bit ok;
    in_t item;
    for (int i = 0; i < 54; i++) hdr[i] = 8'($urandom);
    ce = (depth == 4 || depth == 8) ? ((cnt == 0) ? (longint'(1) << depth) : cnt) : 16;
    off = 54 + 4 * ce + gap_bytes;
    hdr[0] = sig_ok ? BMP_SIGNATURE[7:0] : 8'h43;
    hdr[1] = BMP_SIGNATURE[15:8];
    put32(hdr, 10, off);
    put32(hdr, 18, w);
    put32(hdr, 22, h);
    hdr[28] = 8'(depth);
    hdr[29] = 8'(depth >> 8);
    put32(hdr, 30, comp);
    put32(hdr, 46, cnt);
    ah = (h < 0) ? -h : h;
    ok = sig_ok && (depth == 4 || depth == 8) && comp == 0 && w > 0 && h != 0 &&
         w <= DefMaxWidth && ah <= DefMaxHeight && ce >= 0 && ce <= DefPaletteSlots &&
         gap_bytes >= 0;
    foreach (hdr[i]) f.push_back(hdr[i]);
    if (ok) begin
      // Palette: black, near black and white first, then random colors.
      for (int i = 0; i < ce; i++) begin
        for (int k = 0; k < 4; k++) begin
          if (i == 0 && k < 3) f.push_back(8'h00);
          else if (i == 1 && k < 3) f.push_back((k == 0) ? 8'h07 : 8'h00);
          else if (i == 2) f.push_back(8'hFF);
          else f.push_back(8'($urandom));
        end
      end
      for (int i = 0; i < gap_bytes; i++) f.push_back(8'($urandom));
      stride = ((depth * w + 31) / 32) * 4;
      for (longint i = 0; i < stride * ah; i++) f.push_back(8'($urandom));
    end
    for (int i = 0; i < junk; i++) f.push_back(8'($urandom));
    if (cut < 0) cut = $urandom_range(1, f.size() - 1);
    if (cut > 0) while (f.size() > cut) void'(f.pop_back());
    foreach (f[i]) begin
      item.data_byte = f[i];
      item.final_byte = (i == f.size() - 1);
      byte_queue.push_back(item);
    end
  endtask

  task automatic queue_random_file();
    int depth, pick;
    longint w, h, cnt;
    depth = $urandom_range(0, 1) ? 8 : 4;
    w = $urandom_range(1, 7);
    h = $urandom_range(1, 3);
    if ($urandom_range(0, 1)) h = -h;
    cnt = (depth == 4 && $urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
    pick = $urandom_range(0, 9);
    if (pick <= 6) queue_file(1, depth, 0, w, h, cnt, $urandom_range(0, 3), 0, 0);
    else if (pick == 7) queue_file(1, depth, 0, w, h, cnt, $urandom_range(0, 3), -1, 0);
    else if (pick == 8) queue_file($urandom_range(0, 1), depth, $urandom_range(0, 1),
                                   w, h, cnt, 0, 0, $urandom_range(0, 3));
    else queue_file(1, depth, 0, w, h, cnt, $urandom_range(0, 3), 0, $urandom_range(1, 4));
  endtask

  // Waits until every queued byte has been taken and every result has come.
  task automatic drain();
    while (byte_queue.size() != 0 || byte_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_clamp(logic v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    clamp_black = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Byte sender: offers queued bytes with random idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
      byte_if.data <= '0;
      send_gap <= 0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        predict_byte(byte_if.data.data_byte, byte_if.data.final_byte);
      end
      if (byte_if.valid && !byte_if.ready) begin
        // Hold the offered byte until the transfer happens.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        byte_if.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        send_gap <= $urandom_range(0, 16);
        byte_if.valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        byte_if.valid <= 1'b1;
        byte_if.data <= byte_queue.pop_front();
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: checks each transfer and stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
      held <= 1'b0;
      results_seen = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result %p", res_if.data);
          mismatch_count++;
        end else if (expected_results[0] !== res_if.data) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected %p", expected_results[0]);
            $display("          actual   %p", res_if.data);
          end
          mismatch_count++;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else if (results_seen >= 12 && !held) begin
        // One long stall so the result queue fills and back-pressures input.
        held <= 1'b1;
        hold_left <= 300;
        res_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        recv_gap <= $urandom_range(0, 16);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int added;
    clamp_black = 1'b0;
    clear_file();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed files: two good images, an early end inside the header and a
    // data offset that points into the palette.
    queue_file(1, 8, 0, 3, 2, 2, 2, 0, 0);
    queue_file(1, 4, 0, 3, -2, 3, 0, 0, 0);
    queue_file(1, 8, 0, 2, 1, 2, 0, 20, 0);
    queue_file(1, 8, 0, 2, 1, 2, -4, 0, 0);
    drain();

    // Random files with the clamp on; this last stretch runs without idling.
    write_clamp(1'b1);
    quiet = 1'b1;
    added = 0;
    while (added < 60) begin
      added -= byte_queue.size();
      queue_random_file();
      added += byte_queue.size();
    end
    drain();

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/bmp_pkg.sv
hdl/bmp_stream_if.sv
hdl/bmp_parse.sv
hdl/bmp_outq.sv
hdl/bmp_indexed_image_decoder.sv
tb/sv/bmp_indexed_image_decoder_tb.sv
